/* rtl/length_prefixed_frame_receiver_defines.svh */
// ----------------------------------------------------------------------------
// Frame receiver assertion macros
// Shared concurrent-check wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication check.
`define LPFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpfr check failed");

// Next-cycle implication check.
`define LPFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpfr check failed");

`endif

/* rtl/lpfr_pkg.sv */
// ----------------------------------------------------------------------------
// lpfr_pkg
// Types, constants and the byte-wide CRC-16 update for the frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpfr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 512;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0]  START_SHORT  = 8'h02;
  localparam logic [7:0]  START_LONG   = 8'h03;
  localparam logic [7:0]  END_BYTE     = 8'h03;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] LONG_LEN_MIN = 16'd255;

  typedef enum logic [1:0] {
    STAT_BUSY     = 2'd0,
    STAT_GOOD     = 2'd1,
    STAT_ERROR    = 2'd2,
    STAT_DISABLED = 2'd3
  } status_e;

  // Byte with its precomputed markers.
  typedef struct packed {
    logic [7:0] data;
    logic       is_short_start;
    logic       is_long_start;
    logic       is_end;
    logic       is_zero;
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Result beat, status in the low bits.
  typedef struct packed {
    logic [9:0] frame_len;
    logic [8:0] pidx;
    logic [7:0] pbyte;
    logic       pvalid;
    status_e    status;
  } res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/length_prefixed_frame_receiver.sv */
// Path: an accepted byte is written into the queue, then popped through the
//   frame engine into its result register, which drives the result beat.
// Throughput: one byte per cycle while the result sink keeps up; the byte-wide
//   CRC-16 update and length compare in the frame engine are combinational.
// Reset: rst_ni low clears the enable bit, the frame state, the queue and the
//   output valid at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Byte-stream frame checker: start byte, 1- or 2-byte length, payload,
// big-endian CRC-16 (poly 0x1021, init 0) over the payload, end byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "length_prefixed_frame_receiver_defines.svh"

module length_prefixed_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = lpfr_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned QUEUE_DEPTH = lpfr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Config: enable bit, written whenever cfg_we_i is high.
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  // Input beats: one received byte each.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // Result beats.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o    // [1:0] status, [2] payload_valid,
                                             // [10:3] payload_byte,
                                             // [19:11] byte position in payload,
                                             // [29:20] frame_payload_length,
                                             // [31:30] zero
);

  logic              enable_q;
  logic              q_push;
  lpfr_pkg::cls_t    q_push_data;
  logic              q_pop;
  lpfr_pkg::cls_t    q_head;
  lpfr_pkg::q_stat_t q_stat;
  lpfr_pkg::res_t    res;
  logic              out_stall;
  logic              out_good;

  // Enable register. Frame state is untouched by writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  // Front: tags each byte with the markers the frame engine tests.
  lpfr_front u_front (
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  // Queue decouples input acceptance from the frame engine's stalls.
  lpfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  // Back: one byte per pop through the frame state machine into the result
  // register; pops when the queue holds a byte and the result register is free or being drained.
  lpfr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enable_i   (enable_q),
    .head_i     (q_head),
    .q_stat_i   (q_stat),
    .pop_o      (q_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_res_o    (res)
  );

  assign m_axis_tdata_o = {2'b00, res};

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_good  = m_axis_tvalid_o && (res.status == lpfr_pkg::STAT_GOOD);

  // Every byte taken by the engine shows up as a result beat next cycle.
  `LPFR_ASSERT_NEXT(a_pop_gives_beat, clk_i, rst_ni, q_pop, m_axis_tvalid_o)
  // A stalled result beat holds the engine.
  `LPFR_ASSERT_IMPL(a_no_pop_on_stall, clk_i, rst_ni, out_stall, !q_pop)
  // A good frame is reported on its end byte, never on a payload byte.
  `LPFR_ASSERT_IMPL(a_good_not_payload, clk_i, rst_ni, out_good, !res.pvalid)

endmodule

`default_nettype wire

/* rtl/lpfr_front.sv */
// ----------------------------------------------------------------------------
// lpfr_front
// Input side: takes byte beats and tags start, end and zero markers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpfr_front (
  input  wire logic             s_tvalid_i,
  output logic                  s_tready_o,
  input  wire logic [7:0]       s_tdata_i,
  input  wire lpfr_pkg::q_stat_t q_stat_i,
  output logic                  push_o,
  output lpfr_pkg::cls_t        push_data_o
);

  assign s_tready_o = !q_stat_i.full;
  assign push_o     = s_tvalid_i && !q_stat_i.full;

  always_comb begin
    push_data_o.data           = s_tdata_i;
    push_data_o.is_short_start = (s_tdata_i == lpfr_pkg::START_SHORT);
    push_data_o.is_long_start  = (s_tdata_i == lpfr_pkg::START_LONG);
    push_data_o.is_end         = (s_tdata_i == lpfr_pkg::END_BYTE);
    push_data_o.is_zero        = (s_tdata_i == 8'h00);
  end

endmodule

`default_nettype wire

/* rtl/lpfr_queue.sv */
// ----------------------------------------------------------------------------
// lpfr_queue
// Short register queue between the classifier and the frame engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpfr_queue #(
  parameter int unsigned DEPTH = lpfr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire lpfr_pkg::cls_t    push_data_i,
  input  wire logic              pop_i,
  output lpfr_pkg::cls_t         head_o,
  output lpfr_pkg::q_stat_t      stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lpfr_pkg::cls_t entry_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/lpfr_back.sv */
// ----------------------------------------------------------------------------
// lpfr_back
// Frame engine: header/length checks, payload echo, running CRC, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpfr_back #(
  parameter int unsigned MAX_PAYLOAD = lpfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              enable_i,
  input  wire lpfr_pkg::cls_t    head_i,
  input  wire lpfr_pkg::q_stat_t q_stat_i,
  output logic                   pop_o,
  output logic                   m_tvalid_o,
  input  wire logic              m_tready_i,
  output lpfr_pkg::res_t         m_res_o
);

  localparam int unsigned LW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [16:0] MAX_LEN17 = 17'(MAX_PAYLOAD);

  typedef enum logic [7:0] {
    S_START   = 8'b0000_0001,
    S_LEN_S   = 8'b0000_0010,
    S_LEN_HI  = 8'b0000_0100,
    S_LEN_LO  = 8'b0000_1000,
    S_PAYLOAD = 8'b0001_0000,
    S_CRC_HI  = 8'b0010_0000,
    S_CRC_LO  = 8'b0100_0000,
    S_END     = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [LW-1:0]   len_q, len_d;
  logic [LW-1:0]   idx_q, idx_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      hi_q, hi_d;
  logic            out_valid_q, out_valid_d;
  lpfr_pkg::res_t  res_q, res_d;
  lpfr_pkg::res_t  res;
  logic [15:0]     len16;
  logic [16:0]     short17;

  assign pop_o      = !q_stat_i.empty && (!out_valid_q || m_tready_i);
  assign m_tvalid_o = out_valid_q;
  assign m_res_o    = res_q;
  assign len16      = {hi_q, head_i.data};
  assign short17    = {9'd0, head_i.data};

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    idx_d      = idx_q;
    crc_d      = crc_q;
    hi_d       = hi_q;
    res        = '0;
    res.status = lpfr_pkg::STAT_BUSY;

    if (!enable_i) begin
      res.status = lpfr_pkg::STAT_DISABLED;
    end else begin
      unique case (state_q)
        S_START: begin
          if (head_i.is_short_start) begin
            state_d = S_LEN_S;
          end else if (head_i.is_long_start) begin
            state_d = S_LEN_HI;
          end else begin
            res.status = lpfr_pkg::STAT_ERROR;
          end
        end
        S_LEN_S: begin
          if (head_i.is_zero || (short17 > MAX_LEN17)) begin
            res.status = lpfr_pkg::STAT_ERROR;
            state_d    = S_START;
          end else begin
            len_d   = LW'(head_i.data);
            idx_d   = '0;
            crc_d   = '0;
            state_d = S_PAYLOAD;
          end
        end
        S_LEN_HI: begin
          hi_d    = head_i.data;
          state_d = S_LEN_LO;
        end
        S_LEN_LO: begin
          if ((len16 < lpfr_pkg::LONG_LEN_MIN) || ({1'b0, len16} > MAX_LEN17)) begin
            res.status = lpfr_pkg::STAT_ERROR;
            state_d    = S_START;
          end else begin
            len_d   = LW'(len16);
            idx_d   = '0;
            crc_d   = '0;
            state_d = S_PAYLOAD;
          end
        end
        S_PAYLOAD: begin
          res.pvalid = 1'b1;
          res.pbyte  = head_i.data;
          res.pidx   = 9'(idx_q);
          crc_d      = lpfr_pkg::crc_feed(crc_q, head_i.data);
          if (idx_q == len_q - LW'(1)) begin
            state_d = S_CRC_HI;
          end else begin
            idx_d = idx_q + LW'(1);
          end
        end
        S_CRC_HI: begin
          hi_d    = head_i.data;
          state_d = S_CRC_LO;
        end
        S_CRC_LO: begin
          crc_d   = crc_q ^ {hi_q, head_i.data};
          state_d = S_END;
        end
        S_END: begin
          if (head_i.is_end && (crc_q == 16'h0000)) begin
            res.status    = lpfr_pkg::STAT_GOOD;
            res.frame_len = 10'(len_q);
          end else begin
            res.status = lpfr_pkg::STAT_ERROR;
          end
          state_d = S_START;
        end
        default: begin
          res.status = lpfr_pkg::STAT_ERROR;
          state_d    = S_START;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      res_d       = res;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_START;
      len_q       <= '0;
      idx_q       <= '0;
      crc_q       <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        state_q <= state_d;
        len_q   <= len_d;
        idx_q   <= idx_d;
        crc_q   <= crc_d;
        hi_q    <= hi_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

`default_nettype wire

/* tb/tb_length_prefixed_frame_receiver.sv */
// ----------------------------------------------------------------------------
// tb_length_prefixed_frame_receiver
// Self-checking bench for the frame receiver. Bytes go in on the input
// stream. A cycle-free model of the frame parser predicts one result beat
// per byte, and the beats coming out are checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_length_prefixed_frame_receiver;

  localparam int unsigned MAX_PAY     = lpfr_pkg::MAX_PAYLOAD_DEF;
  localparam int unsigned ITEM_TARGET = 1850;
  localparam int unsigned CALM_ITEMS  = 120;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {
    HDR_NONE  = 2'd0,
    HDR_SHORT = 2'd1,
    HDR_LONG  = 2'd2
  } hdr_kind_e;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte   = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_data;

  // Model of the parser state, updated once per accepted byte.
  bit          rx_enable;
  hdr_kind_e   fr_kind;
  logic [9:0]  fr_pos;
  logic [9:0]  fr_total;
  logic [7:0]  fr_len_hi;
  logic [9:0]  fr_len;
  logic [15:0] fr_crc;
  logic [7:0]  fr_crc_hi;

  lpfr_pkg::res_t pending_results[$];
  logic [7:0]     frame_bytes[$];

  int unsigned err_count;
  int unsigned bytes_sent;
  int unsigned beats_checked;
  int unsigned n_good;
  int unsigned n_bad;
  int unsigned n_off;
  int unsigned n_payload;
  int unsigned cycle_count;

  // Idle control. The sink's hold-off is requested by bumping hold_requests.
  bit          sender_idles = 1'b1;
  bit          sink_idles   = 1'b1;
  bit          calm         = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_left    = 0;

  length_prefixed_frame_receiver u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_byte),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit, far above the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d beats still due", cycle_count,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model --

  // CRC-16, poly 0x1021, MSB first, one bit at a time.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? lpfr_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void clear_frame();
    fr_kind   = HDR_NONE;
    fr_pos    = '0;
    fr_total  = '0;
    fr_len_hi = '0;
    fr_len    = '0;
    fr_crc    = '0;
    fr_crc_hi = '0;
  endfunction

  // Result beat caused by one received byte; advances the model state.
  function automatic lpfr_pkg::res_t predict_frame_beat(input logic [7:0] b);
    lpfr_pkg::res_t r;
    int unsigned    pos;
    int unsigned    len;
    int unsigned    hdr;
    r = '0;
    r.status = lpfr_pkg::STAT_BUSY;
    if (!rx_enable) begin
      r.status = lpfr_pkg::STAT_DISABLED;
    end else begin
      pos    = fr_pos + 1;
      fr_pos = pos[9:0];
      if (pos == 1) begin
        if (b == lpfr_pkg::START_SHORT) begin
          fr_kind = HDR_SHORT;
        end else if (b == lpfr_pkg::START_LONG) begin
          fr_kind = HDR_LONG;
        end else begin
          clear_frame();
          r.status = lpfr_pkg::STAT_ERROR;
        end
      end else if (fr_kind == HDR_SHORT && pos == 2) begin
        len = b;
        if (len == 0 || len > MAX_PAY) begin
          clear_frame();
          r.status = lpfr_pkg::STAT_ERROR;
        end else begin
          fr_len   = len[9:0];
          fr_total = 10'(len + 5);
          fr_crc   = '0;
        end
      end else if (fr_kind == HDR_LONG && pos == 2) begin
        fr_len_hi = b;
      end else if (fr_kind == HDR_LONG && pos == 3) begin
        len = {fr_len_hi, b};
        if (len < lpfr_pkg::LONG_LEN_MIN || len > MAX_PAY) begin
          clear_frame();
          r.status = lpfr_pkg::STAT_ERROR;
        end else begin
          fr_len   = len[9:0];
          fr_total = 10'(len + 6);
          fr_crc   = '0;
        end
      end else if (fr_total != 0) begin
        hdr = 1 + int'(fr_kind);
        if (pos <= hdr + fr_len) begin
          r.pvalid = 1'b1;
          r.pbyte  = b;
          r.pidx   = 9'(pos - hdr - 1);
          fr_crc   = crc16_update(fr_crc, b);
        end else if (pos == hdr + fr_len + 1) begin
          fr_crc_hi = b;
        end else if (pos == hdr + fr_len + 2) begin
          // Folding the received CRC in leaves zero on a match.
          fr_crc = fr_crc ^ {fr_crc_hi, b};
        end else begin
          if (b == lpfr_pkg::END_BYTE && fr_crc == 16'h0000) begin
            r.status    = lpfr_pkg::STAT_GOOD;
            r.frame_len = fr_len;
          end else begin
            r.status = lpfr_pkg::STAT_ERROR;
          end
          clear_frame();
        end
      end else begin
        // Lost frame: past the header with no length known.
        clear_frame();
        r.status = lpfr_pkg::STAT_ERROR;
      end
    end
    return r;
  endfunction

  // -------------------------------------------------------------- checking --

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH beat %0d %s: got 0x%0h want 0x%0h", beats_checked, what,
             got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    lpfr_pkg::res_t got;
    lpfr_pkg::res_t want;
    if (rst_ni && out_valid && out_ready) begin
      got = out_data[29:0];
      if (pending_results.size() == 0) begin
        report_mismatch("beat with none due", out_data, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status)
          report_mismatch("status", got.status, want.status);
        if (got.pvalid != want.pvalid)
          report_mismatch("payload_valid", got.pvalid, want.pvalid);
        if (got.pbyte != want.pbyte)
          report_mismatch("payload_byte", got.pbyte, want.pbyte);
        if (got.pidx != want.pidx)
          report_mismatch("payload position", got.pidx, want.pidx);
        if (got.frame_len != want.frame_len)
          report_mismatch("frame_payload_length", got.frame_len, want.frame_len);
        if (out_data[31:30] != 2'b00)
          report_mismatch("pad bits", out_data[31:30], 0);
        case (want.status)
          lpfr_pkg::STAT_GOOD:     n_good++;
          lpfr_pkg::STAT_ERROR:    n_bad++;
          lpfr_pkg::STAT_DISABLED: n_off++;
          default: ;
        endcase
        if (want.pvalid) n_payload++;
      end
      beats_checked++;
    end
  end

  // ------------------------------------------------------------- result sink --

  // Random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin : result_sink
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES - 1;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && sink_idles && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // -------------------------------------------------------------- stimulus --

  // Offer one byte and wait for its handshake; valid stays high afterwards.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && sender_idles && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk_i); while (!in_ready);
    pending_results.push_back(predict_frame_beat(b));
    bytes_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Enable is only written with the block idle; frame state is kept.
  task automatic write_enable(input bit v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    rx_enable = v;
  endtask

  // Builds a frame in frame_bytes. A length the block rejects yields the
  // header only. fill < 0 gives random payload.
  function automatic void make_frame(input int unsigned len, input bit long_hdr,
                                     input bit bad_crc, input bit bad_end,
                                     input int fill);
    logic [15:0] crc;
    logic [7:0]  b;
    frame_bytes.delete();
    crc = '0;
    if (long_hdr) begin
      frame_bytes.push_back(lpfr_pkg::START_LONG);
      frame_bytes.push_back(len[15:8]);
      frame_bytes.push_back(len[7:0]);
      if (len < lpfr_pkg::LONG_LEN_MIN || len > MAX_PAY) return;
    end else begin
      frame_bytes.push_back(lpfr_pkg::START_SHORT);
      frame_bytes.push_back(len[7:0]);
      if (len == 0) return;
    end
    for (int i = 0; i < int'(len); i++) begin
      b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      frame_bytes.push_back(b);
      crc = crc16_update(crc, b);
    end
    if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
    if (bad_end) begin
      do b = 8'($urandom_range(0, 255)); while (b == lpfr_pkg::END_BYTE);
      frame_bytes.push_back(b);
    end else begin
      frame_bytes.push_back(lpfr_pkg::END_BYTE);
    end
  endfunction

  // Sends n bytes from the front of frame_bytes, all of them for n = 0.
  task automatic send_pending(input int unsigned n);
    int unsigned cnt;
    cnt = 0;
    while (frame_bytes.size() != 0 && (n == 0 || cnt < n)) begin
      send_byte(frame_bytes.pop_front());
      cnt++;
    end
  endtask

  // ------------------------------------------------------------------ tests --

  // Field extremes and every error path, one frame or fragment each.
  task automatic test_directed_frames();
    write_enable(1'b1);
    make_frame(1, 1'b0, 1'b0, 1'b0, 8'h00); send_pending(0);
    make_frame(1, 1'b0, 1'b0, 1'b0, 8'hFF); send_pending(0);
    send_byte(8'hFF);                                         // bad start byte
    send_byte(8'h00);
    make_frame(0, 1'b0, 1'b0, 1'b0, -1); send_pending(0);     // short length zero
    make_frame(254, 1'b1, 1'b0, 1'b0, -1); send_pending(0);   // long form too short
    make_frame(513, 1'b1, 1'b0, 1'b0, -1); send_pending(0);   // long form too long
    make_frame(1, 1'b0, 1'b1, 1'b0, -1); send_pending(0);     // CRC mismatch
    make_frame(1, 1'b0, 1'b0, 1'b1, -1); send_pending(0);     // wrong end byte
  endtask

  // Disabled bytes change nothing, also when dropped into a frame.
  task automatic test_enable_switching();
    write_enable(1'b0);
    send_byte(lpfr_pkg::START_SHORT);
    send_byte(lpfr_pkg::START_LONG);
    send_byte(8'h00);
    send_byte(8'hFF);
    repeat (6) send_byte(8'($urandom_range(0, 255)));
    write_enable(1'b1);
    make_frame(6, 1'b0, 1'b0, 1'b0, -1);
    send_pending(4);
    write_enable(1'b0);
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    write_enable(1'b1);
    send_pending(0);
  endtask

  // Long form at both length limits; 512 also sets the top index bits.
  task automatic test_long_frames();
    make_frame(lpfr_pkg::LONG_LEN_MIN, 1'b1, 1'b0, 1'b0, -1); send_pending(0);
    make_frame(MAX_PAY, 1'b1, 1'b0, 1'b0, -1); send_pending(0);
  endtask

  // Sink holds off while frames keep coming, so the input side backs up.
  task automatic test_backpressure();
    hold_requests <= hold_requests + 1;
    repeat (3) begin
      make_frame(8, 1'b0, 1'b0, 1'b0, -1);
      send_pending(0);
    end
  endtask

  // Mostly well-formed short frames with random content, mixed with broken frames,
  // cut-offs, bad lengths, line noise, long frames and one disabled stretch.
  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned len;
    bit          off_done;
    off_done = 1'b0;
    while (bytes_sent < ITEM_TARGET - CALM_ITEMS) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      sink_idles   <= ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 255)
                                         : $urandom_range(1, 16);
      if (pick < 58) begin
        make_frame(len, 1'b0, 1'b0, 1'b0, -1); send_pending(0);
      end else if (pick < 66) begin
        make_frame(len, 1'b0, 1'b1, 1'b0, -1); send_pending(0);
      end else if (pick < 72) begin
        make_frame(len, 1'b0, 1'b0, 1'b1, -1); send_pending(0);
      end else if (pick < 80) begin
        // Frame cut short; the next bytes land mid-frame.
        make_frame($urandom_range(1, 16), 1'b0, 1'b0, 1'b0, -1);
        send_pending($urandom_range(1, frame_bytes.size() - 1));
        frame_bytes.delete();
      end else if (pick < 87) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
        case ($urandom_range(0, 2))
          0: make_frame(0, 1'b0, 1'b0, 1'b0, -1);
          1: make_frame($urandom_range(0, 254), 1'b1, 1'b0, 1'b0, -1);
          default: make_frame($urandom_range(513, 65535), 1'b1, 1'b0, 1'b0, -1);
        endcase
        send_pending(0);
      end else if (pick < 94) begin
        make_frame($urandom_range(255, 262), 1'b1, $urandom_range(0, 1), 1'b0, -1);
        send_pending(0);
      end else begin
        // Payload made of start and end byte values.
        make_frame(len, 1'b0, 1'b0, 1'b0, ($urandom_range(0, 1) != 0) ? 2 : 3);
        send_pending(0);
      end
      if (!off_done && bytes_sent > (ITEM_TARGET + 1000) / 2) begin
        off_done = 1'b1;
        write_enable(1'b0);
        repeat (16) send_byte(8'($urandom_range(0, 255)));
        write_enable(1'b1);
      end
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    calm <= 1'b1;
    while (bytes_sent < ITEM_TARGET) begin
      make_frame($urandom_range(1, 12), 1'b0, $urandom_range(0, 4) == 0, 1'b0, -1);
      send_pending(0);
    end
  endtask

  initial begin
    rx_enable = 1'b0;
    clear_frame();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_enable_switching();
    test_long_frames();
    test_backpressure();
    test_random_traffic();
    test_full_rate();

    drain_results();
    $display("Sent %0d bytes, checked %0d result beats (%0d payload echoes).",
             bytes_sent, beats_checked, n_payload);
    $display("Frames good: %0d, error reports: %0d, disabled beats: %0d.",
             n_good, n_bad, n_off);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
